[rtl/fifo_run_queue_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// Run queue scheduler assertion macros
// Assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_RUN_QUEUE_SCHEDULER_MACROS_SVH
`define FIFO_RUN_QUEUE_SCHEDULER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define FRQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("run queue scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("run queue scheduler assertion failed");

`else

`define FRQS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/frqs_pkg.sv]
// ----------------------------------------------------------------------------
// Run queue scheduler package
// Sizes, codes, state type and queue pointer helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frqs_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int TASK_ID_BITS = 16;
    localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TASK_ID_BITS-1:0] t_task;
    typedef logic [PTR_BITS-1:0]     t_ptr;
    typedef logic [FILL_BITS-1:0]    t_fill;

    typedef enum logic [2:0] {
        ACT_NEW       = 3'd0,
        ACT_RUNNABLE  = 3'd1,
        ACT_BLOCKED   = 3'd2,
        ACT_DEPARTED  = 3'd3,
        ACT_DEAD      = 3'd4,
        ACT_YIELD     = 3'd5,
        ACT_PREEMPTED = 3'd6,
        ACT_SCHEDULE  = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        DEC_HANDLED     = 3'd0,
        DEC_YIELD_CLASS = 3'd1,
        DEC_IDLE        = 3'd2,
        DEC_RUN         = 3'd3,
        DEC_COMMIT_FAIL = 3'd4
    } t_decision;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_FULL        = 2'd1,
        ERR_NOT_CURRENT = 2'd2
    } t_error;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE,
        ST_POPD
    } t_state;

    // Physical slot of queue position pos, counted from head.
    function automatic t_ptr slot_add(input t_ptr head, input t_ptr pos);
        logic [PTR_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (PTR_BITS + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_BITS + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_BITS-1:0];
    endfunction

    function automatic t_ptr ptr_inc(input t_ptr p);
        t_ptr r;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        t_ptr r;
        if (p == '0) begin
            r = PTR_BITS'(QUEUE_DEPTH - 1);
        end else begin
            r = p - PTR_BITS'(1);
        end
        return r;
    endfunction

endpackage

[rtl/fifo_run_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// FIFO run queue scheduler
// Per-CPU FIFO round-robin run queue with one current-task slot.
// ----------------------------------------------------------------------------
//
//  Channel   Valid     Ready     Payload
//  -------   -------   -------   ------------------------------------------
//  event     i_valid   o_ready   i_action i_task_id i_is_runnable i_boosted
//                                i_commit_ok
//  result    o_valid   i_ready   o_decision o_target_task o_error_code
//                                o_queue_count
//
//  Most events are captured into the event registers on acceptance, then
//  update the state and load the result in the execute state. A schedule that
//  pops the queue head adds a read of the queue memory before the result is
//  loaded. A departed task that is not current is erased by walking the
//  occupied window through the single memory read port, one entry per cycle,
//  shifting later entries down behind it, and draining the walk at the end.
//  Reset is synchronous and active low; it empties the queue and clears the
//  current slot, and the queue memory itself is not cleared. A stalled
//  result stays in the output register while the next event is accepted.
//
`timescale 1ns / 1ps
`include "fifo_run_queue_scheduler_macros.svh"

module fifo_run_queue_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_action,
    input  logic [frqs_pkg::TASK_ID_BITS-1:0] i_task_id,
    input  logic                              i_is_runnable,
    input  logic                              i_boosted,
    input  logic                              i_commit_ok,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_decision,
    output logic [frqs_pkg::TASK_ID_BITS-1:0] o_target_task,
    output logic [1:0]                        o_error_code,
    output logic [frqs_pkg::FILL_BITS-1:0]    o_queue_count
);

    // Queue memory: one write port and one registered read port.
    frqs_pkg::t_task mem [frqs_pkg::QUEUE_DEPTH];

    frqs_pkg::t_state    r_state,     n_state;
    frqs_pkg::t_action   r_act;
    frqs_pkg::t_task     r_task;
    logic                r_runnable;
    logic                r_boosted;
    logic                r_commit;
    frqs_pkg::t_ptr      r_head,      n_head;
    frqs_pkg::t_fill     r_fill,      n_fill;
    logic                r_cur_valid, n_cur_valid;
    frqs_pkg::t_task     r_cur_task,  n_cur_task;
    frqs_pkg::t_fill     r_pos,       n_pos;
    logic                r_chk,       n_chk;
    frqs_pkg::t_ptr      r_chk_pos,   n_chk_pos;
    logic                r_found,     n_found;
    logic                r_o_valid,   n_o_valid;
    frqs_pkg::t_decision r_o_decision, n_o_decision;
    frqs_pkg::t_task     r_o_target,  n_o_target;
    frqs_pkg::t_error    r_o_error,   n_o_error;
    frqs_pkg::t_fill     r_o_count,   n_o_count;
    logic                n_o_load;
    frqs_pkg::t_task     r_rd_data;

    logic                w_en;
    frqs_pkg::t_ptr      w_addr;
    frqs_pkg::t_task     w_data;
    logic                rd_en;
    frqs_pkg::t_ptr      rd_addr;

    logic                out_free;
    logic                is_cur;
    logic                q_full;
    logic                in_take;

    assign in_take  = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign is_cur   = r_cur_valid && (r_cur_task == r_task);
    assign q_full   = (r_fill == frqs_pkg::FILL_BITS'(frqs_pkg::QUEUE_DEPTH));

    // Memory ports. Writes trail the walk's reads, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // The captured event is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_act      <= frqs_pkg::t_action'(i_action);
            r_task     <= i_task_id;
            r_runnable <= i_is_runnable;
            r_boosted  <= i_boosted;
            r_commit   <= i_commit_ok;
        end
        if (n_o_load) begin
            r_o_decision <= n_o_decision;
            r_o_target   <= n_o_target;
            r_o_error    <= n_o_error;
            r_o_count    <= n_o_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frqs_pkg::ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_cur_valid <= 1'b0;
            r_cur_task  <= '0;
            r_pos       <= '0;
            r_chk       <= 1'b0;
            r_chk_pos   <= '0;
            r_found     <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_cur_valid <= n_cur_valid;
            r_cur_task  <= n_cur_task;
            r_pos       <= n_pos;
            r_chk       <= n_chk;
            r_chk_pos   <= n_chk_pos;
            r_found     <= n_found;
            r_o_valid   <= n_o_valid;
        end
    end

    // Sequencer: next state, queue updates and result loading.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_cur_valid  = r_cur_valid;
        n_cur_task   = r_cur_task;
        n_pos        = r_pos;
        n_chk        = r_chk;
        n_chk_pos    = r_chk_pos;
        n_found      = r_found;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_load     = 1'b0;
        n_o_decision = frqs_pkg::DEC_HANDLED;
        n_o_target   = '0;
        n_o_error    = frqs_pkg::ERR_OK;
        n_o_count    = r_fill;
        w_en         = 1'b0;
        w_addr       = frqs_pkg::slot_add(r_head, r_fill[frqs_pkg::PTR_BITS-1:0]);
        w_data       = r_task;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        o_ready      = 1'b0;

        unique case (r_state)
            frqs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = frqs_pkg::ST_EXEC;
                end
            end

            frqs_pkg::ST_EXEC: begin
                if (r_act == frqs_pkg::ACT_DEPARTED && !is_cur) begin
                    // Erase the first queued copy by walking the window.
                    n_pos   = '0;
                    n_chk   = 1'b0;
                    n_found = 1'b0;
                    n_state = frqs_pkg::ST_WALK;
                end else if (r_act == frqs_pkg::ACT_SCHEDULE && !r_boosted &&
                             !r_cur_valid && r_fill != '0) begin
                    // Read the queue head; the pop completes in ST_POPD.
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = frqs_pkg::ST_POPD;
                end else if (out_free) begin
                    n_o_load  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = frqs_pkg::ST_IDLE;
                    unique case (r_act)
                        frqs_pkg::ACT_NEW,
                        frqs_pkg::ACT_RUNNABLE: begin
                            if (r_runnable || r_act == frqs_pkg::ACT_RUNNABLE) begin
                                if (q_full) begin
                                    n_o_error = frqs_pkg::ERR_FULL;
                                end else begin
                                    w_en   = 1'b1;
                                    n_fill = r_fill + frqs_pkg::FILL_BITS'(1);
                                end
                            end
                        end
                        frqs_pkg::ACT_BLOCKED,
                        frqs_pkg::ACT_DEPARTED: begin
                            if (!is_cur) begin
                                n_o_error = frqs_pkg::ERR_NOT_CURRENT;
                            end else begin
                                n_cur_valid = 1'b0;
                            end
                        end
                        frqs_pkg::ACT_DEAD: begin
                        end
                        frqs_pkg::ACT_YIELD,
                        frqs_pkg::ACT_PREEMPTED: begin
                            if (!is_cur) begin
                                n_o_error = frqs_pkg::ERR_NOT_CURRENT;
                            end else if (q_full) begin
                                n_o_error = frqs_pkg::ERR_FULL;
                            end else begin
                                w_en        = 1'b1;
                                n_fill      = r_fill + frqs_pkg::FILL_BITS'(1);
                                n_cur_valid = 1'b0;
                                if (r_act == frqs_pkg::ACT_PREEMPTED) begin
                                    w_addr = frqs_pkg::ptr_dec(r_head);
                                    n_head = frqs_pkg::ptr_dec(r_head);
                                end
                            end
                        end
                        frqs_pkg::ACT_SCHEDULE: begin
                            if (r_boosted) begin
                                n_o_decision = frqs_pkg::DEC_YIELD_CLASS;
                            end else if (r_cur_valid) begin
                                n_o_target   = r_cur_task;
                                n_o_decision = r_commit ? frqs_pkg::DEC_RUN
                                                        : frqs_pkg::DEC_COMMIT_FAIL;
                            end else begin
                                n_o_decision = frqs_pkg::DEC_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_o_count = n_fill;
                end
            end

            frqs_pkg::ST_WALK: begin
                // Issue one read per cycle and check the data of the last one.
                rd_en   = (r_pos < r_fill);
                rd_addr = frqs_pkg::slot_add(r_head, r_pos[frqs_pkg::PTR_BITS-1:0]);
                n_chk   = rd_en;
                if (rd_en) begin
                    n_chk_pos = r_pos[frqs_pkg::PTR_BITS-1:0];
                    n_pos     = r_pos + frqs_pkg::FILL_BITS'(1);
                end
                if (r_chk) begin
                    if (r_found) begin
                        w_en   = 1'b1;
                        w_addr = frqs_pkg::slot_add(r_head,
                                                    r_chk_pos - frqs_pkg::PTR_BITS'(1));
                        w_data = r_rd_data;
                    end else if (r_rd_data == r_task) begin
                        n_found = 1'b1;
                    end
                end
                if (!rd_en && !r_chk) begin
                    n_state = frqs_pkg::ST_DONE;
                end
            end

            frqs_pkg::ST_DONE: begin
                if (out_free) begin
                    if (r_found) begin
                        n_fill = r_fill - frqs_pkg::FILL_BITS'(1);
                    end
                    n_o_load  = 1'b1;
                    n_o_valid = 1'b1;
                    n_o_count = n_fill;
                    n_state   = frqs_pkg::ST_IDLE;
                end
            end

            frqs_pkg::ST_POPD: begin
                if (out_free) begin
                    n_o_target = r_rd_data;
                    if (r_commit) begin
                        n_head       = frqs_pkg::ptr_inc(r_head);
                        n_fill       = r_fill - frqs_pkg::FILL_BITS'(1);
                        n_cur_valid  = 1'b1;
                        n_cur_task   = r_rd_data;
                        n_o_decision = frqs_pkg::DEC_RUN;
                    end else begin
                        // Pop followed by a push to the front leaves the queue as it was.
                        n_o_decision = frqs_pkg::DEC_COMMIT_FAIL;
                    end
                    n_o_load  = 1'b1;
                    n_o_valid = 1'b1;
                    n_o_count = n_fill;
                    n_state   = frqs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = frqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_decision    = r_o_decision;
    assign o_target_task = r_o_target;
    assign o_error_code  = r_o_error;
    assign o_queue_count = r_o_count;

    // The queue never holds more entries than the memory has.
    `FRQS_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1,
        r_fill <= frqs_pkg::FILL_BITS'(frqs_pkg::QUEUE_DEPTH))

    // The memory is never written while the block waits for a transaction.
    `FRQS_ASSERT_IMPL(a_no_idle_write, i_clk, i_rst_n,
        r_state == frqs_pkg::ST_IDLE, !w_en)

    // An accepted transaction always starts execution in the next cycle.
    `FRQS_ASSERT_NEXT(a_take_exec, i_clk, i_rst_n, in_take,
        r_state == frqs_pkg::ST_EXEC)

    // An error result reports no decision and no target.
    `FRQS_ASSERT_IMPL(a_error_result, i_clk, i_rst_n,
        r_o_valid && r_o_error != frqs_pkg::ERR_OK,
        r_o_decision == frqs_pkg::DEC_HANDLED && r_o_target == '0)

endmodule
